@@ rtl/ccbc_pkg.sv @@
package ccbc_pkg;

	localparam int VOLT_W    = 16;
	localparam int CUR_W     = 18;
	localparam int RCUR_W    = 17;
	localparam int CFG_W     = 17;
	localparam int CFG_IDX_W = 3;
	localparam int MASK_N    = 20;
	localparam int DEF_CELLS = 20;

	localparam logic [VOLT_W-1:0] RST_TARGET    = 16'd41000;
	localparam logic [VOLT_W-1:0] RST_DONE_WIN  = 16'd30;
	localparam logic [VOLT_W-1:0] RST_BAL_START = 16'd38000;
	localparam logic [VOLT_W-1:0] RST_BAL_DELTA = 16'd250;
	localparam logic [VOLT_W-1:0] RST_EMERG     = 16'd750;
	localparam logic [VOLT_W-1:0] RST_DRAIN_WIN = 16'd30;
	localparam logic [VOLT_W-1:0] RST_GATE_DLT  = 16'd250;
	localparam logic [RCUR_W-1:0] RST_REMOVAL   = 17'd99900;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET    = 3'd0,
		REG_DONE_WIN  = 3'd1,
		REG_BAL_START = 3'd2,
		REG_BAL_DELTA = 3'd3,
		REG_EMERG     = 3'd4,
		REG_DRAIN_WIN = 3'd5,
		REG_GATE_DLT  = 3'd6,
		REG_REMOVAL   = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		VD_CHARGING = 3'd0,
		VD_GATE_OPEN = 3'd1,
		VD_DRAINING = 3'd2,
		VD_COMPLETE = 3'd3,
		VD_REMOVED  = 3'd4,
		VD_FAULT    = 3'd5
	} verdict_t;

	typedef enum logic [1:0] {
		MA_KEEP,
		MA_CLEAR,
		MA_PASS
	} mask_act_t;

	typedef enum logic {
		ST_IDLE,
		ST_PASS
	} state_t;

endpackage

@@ rtl/ccbc_mask_pass.sv @@
module ccbc_mask_pass
	import ccbc_pkg::*;
#(
	parameter int CELLS = DEF_CELLS,
	localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1,
	localparam int CW = $clog2(CELLS + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [VOLT_W-1:0] wr_data,
	input  logic              start,
	input  logic [CW-1:0]     lim,
	input  logic [VOLT_W-1:0] floor_v,
	input  logic [VOLT_W:0]   thr_v,
	output logic              done,
	output logic [MASK_N-1:0] mask
);

	logic [VOLT_W-1:0] mem [CELLS];

	logic              busy_q;
	logic [CW-1:0]     ptr_q;
	logic [CW-1:0]     lim_q;
	logic [MASK_N-1:0] sel_q;
	logic [MASK_N-1:0] acc_q;
	logic [VOLT_W-1:0] floor_q;
	logic [VOLT_W:0]   thr_q;
	logic              last_issue;

	logic              act_s1;
	logic              last_s1;
	logic [MASK_N-1:0] sel_s1;
	logic [VOLT_W-1:0] rd_data_s1;
	logic              hit;

	assign last_issue = (ptr_q == lim_q - CW'(1));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			rd_data_s1 <= mem[ptr_q[AW-1:0]];
		end
		sel_s1 <= sel_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			ptr_q   <= '0;
			lim_q   <= '0;
			sel_q   <= '0;
			floor_q <= '0;
			thr_q   <= '0;
			act_s1  <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			act_s1  <= busy_q;
			last_s1 <= busy_q && last_issue;
			if (start) begin
				busy_q  <= 1'b1;
				ptr_q   <= '0;
				lim_q   <= lim;
				sel_q   <= MASK_N'(1);
				floor_q <= floor_v;
				thr_q   <= thr_v;
			end else if (busy_q) begin
				ptr_q <= ptr_q + CW'(1);
				sel_q <= sel_q << 1;
				if (last_issue) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign hit  = (rd_data_s1 >= floor_q) && ({1'b0, rd_data_s1} > thr_q);
	assign mask = acc_q | ((act_s1 && hit) ? sel_s1 : '0);
	assign done = act_s1 && last_s1;

	// accumulate one cell per cycle as read data comes back
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
		end else if (act_s1) begin
			acc_q <= mask;
		end
	end

endmodule

@@ rtl/cell_charge_balance_controller.sv @@
// Charge balance controller for a series pack. Cell voltages come in one word per cell in
// pack order; the word flagged last_cell closes the frame and yields one result word with
// the gate state, the balance mask, a verdict and the frame min/max. Cells are stored in a
// CELLS-deep single-port-write memory. A last cell whose branch needs a new mask (drain or
// selective balancing) starts a scan of the memory read port, one cell per cycle, and the
// result word is registered when the scan ends; other branches register it as the last
// cell is accepted. Input is held off while a scan runs or a result word waits to be taken.
// Cells past CELLS in a frame are ignored; cells past the 20th have no mask bit.
module cell_charge_balance_controller
	import ccbc_pkg::*;
#(
	parameter int CELLS = DEF_CELLS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [VOLT_W-1:0]    cell_voltage,
	input  logic                 last_cell,
	input  logic signed [CUR_W-1:0] pack_current,
	input  logic                 fault_active,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [MASK_N-1:0]    balance_mask,
	output logic                 charge_gate_open,
	output logic [2:0]           verdict,
	output logic [VOLT_W-1:0]    min_cell,
	output logic [VOLT_W-1:0]    max_cell,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int AW      = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int CW      = $clog2(CELLS + 1);
	localparam int LIM_MAX = (CELLS < MASK_N) ? CELLS : MASK_N;

	logic [VOLT_W-1:0] target_q, done_win_q, bal_start_q, bal_delta_q;
	logic [VOLT_W-1:0] emerg_q, drain_win_q, gate_dlt_q;
	logic [RCUR_W-1:0] removal_q;

	state_t            st_q, st_d;
	logic [CW-1:0]     cnt_q;
	logic [VOLT_W-1:0] run_min_q, run_max_q;
	logic              gate_q;
	logic [MASK_N-1:0] mask_q;
	logic              out_valid_q;
	verdict_t          verdict_q;
	logic [VOLT_W-1:0] min_q, max_q;

	logic              accept, stored;
	logic [CW-1:0]     cnt_next, lim;
	logic [VOLT_W-1:0] vmin, vmax, spread;
	logic              complete;
	verdict_t          vd;
	logic              gate_d;
	mask_act_t         act;
	logic [VOLT_W-1:0] floor_v;
	logic [VOLT_W:0]   thr_v;
	logic              pass_start;
	logic              pass_done;
	logic [MASK_N-1:0] pass_mask;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= RST_TARGET;
			done_win_q  <= RST_DONE_WIN;
			bal_start_q <= RST_BAL_START;
			bal_delta_q <= RST_BAL_DELTA;
			emerg_q     <= RST_EMERG;
			drain_win_q <= RST_DRAIN_WIN;
			gate_dlt_q  <= RST_GATE_DLT;
			removal_q   <= RST_REMOVAL;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_TARGET:    target_q    <= cfg_data[VOLT_W-1:0];
				REG_DONE_WIN:  done_win_q  <= cfg_data[VOLT_W-1:0];
				REG_BAL_START: bal_start_q <= cfg_data[VOLT_W-1:0];
				REG_BAL_DELTA: bal_delta_q <= cfg_data[VOLT_W-1:0];
				REG_EMERG:     emerg_q     <= cfg_data[VOLT_W-1:0];
				REG_DRAIN_WIN: drain_win_q <= cfg_data[VOLT_W-1:0];
				REG_GATE_DLT:  gate_dlt_q  <= cfg_data[VOLT_W-1:0];
				REG_REMOVAL:   removal_q   <= cfg_data[RCUR_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_ready = (st_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign stored   = (cnt_q < CELLS[CW-1:0]);
	assign cnt_next = stored ? cnt_q + CW'(1) : cnt_q;
	assign lim      = (cnt_next > LIM_MAX[CW-1:0]) ? LIM_MAX[CW-1:0] : cnt_next;

	// frame decision
	always_comb begin
		vmin = run_min_q;
		vmax = run_max_q;
		if (stored && cell_voltage < run_min_q) begin
			vmin = cell_voltage;
		end
		if (stored && cell_voltage > run_max_q) begin
			vmax = cell_voltage;
		end
		spread   = (vmax >= vmin) ? vmax - vmin : '0;
		complete = ({1'b0, vmin} + {1'b0, done_win_q}) >= {1'b0, target_q};
		vd       = VD_CHARGING;
		gate_d   = gate_q;
		act      = MA_KEEP;
		floor_v  = '0;
		thr_v    = {1'b0, vmin} + {1'b0, drain_win_q};
		if (fault_active) begin
			act    = MA_CLEAR;
			gate_d = 1'b1;
			vd     = VD_FAULT;
		end else if (gate_q) begin
			if (spread <= drain_win_q) begin
				act = MA_CLEAR;
				if (complete) begin
					vd = VD_COMPLETE;
				end else begin
					gate_d = 1'b0;
					vd     = VD_CHARGING;
				end
			end else begin
				act = MA_PASS;
				vd  = VD_DRAINING;
			end
		end else if (pack_current > $signed({1'b0, removal_q})) begin
			act    = MA_CLEAR;
			gate_d = 1'b1;
			vd     = VD_REMOVED;
		end else if (spread >= emerg_q) begin
			gate_d = 1'b1;
			vd     = VD_GATE_OPEN;
		end else if (vmax >= target_q && spread > gate_dlt_q) begin
			gate_d = 1'b1;
			vd     = VD_GATE_OPEN;
		end else if (complete) begin
			act    = MA_CLEAR;
			gate_d = 1'b1;
			vd     = VD_COMPLETE;
		end else begin
			act     = MA_PASS;
			floor_v = bal_start_q;
			thr_v   = {1'b0, vmin} + {1'b0, bal_delta_q};
			vd      = VD_CHARGING;
		end
	end

	always_comb begin
		st_d       = st_q;
		pass_start = 1'b0;
		case (st_q)
			ST_IDLE: begin
				if (accept && last_cell && act == MA_PASS) begin
					pass_start = 1'b1;
					st_d       = ST_PASS;
				end
			end
			ST_PASS: begin
				if (pass_done) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	ccbc_mask_pass #(
		.CELLS(CELLS)
	) u_pass (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept && stored),
		.wr_addr (cnt_q[AW-1:0]),
		.wr_data (cell_voltage),
		.start   (pass_start),
		.lim     (lim),
		.floor_v (floor_v),
		.thr_v   (thr_v),
		.done    (pass_done),
		.mask    (pass_mask)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			run_min_q   <= '1;
			run_max_q   <= '0;
			gate_q      <= 1'b0;
			mask_q      <= '0;
			out_valid_q <= 1'b0;
			verdict_q   <= VD_CHARGING;
		end else begin
			// the pass result arrives later; hold the word back until then
			if (pass_done || (accept && last_cell && act != MA_PASS)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				if (last_cell) begin
					cnt_q     <= '0;
					run_min_q <= '1;
					run_max_q <= '0;
					gate_q    <= gate_d;
					verdict_q <= vd;
					if (act == MA_CLEAR) begin
						mask_q <= '0;
					end
				end else begin
					cnt_q     <= cnt_next;
					run_min_q <= vmin;
					run_max_q <= vmax;
				end
			end
			if (pass_done) begin
				mask_q <= pass_mask;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_cell) begin
			min_q <= vmin;
			max_q <= vmax;
		end
	end

	assign out_valid        = out_valid_q;
	assign balance_mask     = mask_q;
	assign charge_gate_open = gate_q;
	assign verdict          = verdict_q;
	assign min_cell         = min_q;
	assign max_cell         = max_q;

`ifndef SYNTHESIS
	a_no_out_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_PASS |-> !out_valid_q)
		else $error("result word pending during mask scan");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CELLS[CW-1:0])
		else $error("cell count past store depth");
	a_done_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		pass_done |-> st_q == ST_PASS)
		else $error("mask scan finished outside scan state");
	a_start_leads_pass: assert property (@(posedge clk) disable iff (!arst_n)
		pass_start |=> st_q == ST_PASS && !in_ready)
		else $error("input open while scan runs");
`endif

endmodule

@@ dv/cell_charge_balance_controller_tb.sv @@
module cell_charge_balance_controller_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ccbc_pkg::*;

	localparam int CELLS          = DEF_CELLS;
	localparam int N_REGS         = 8;
	localparam int N_ITEMS        = 1950;
	localparam int N_PHASES       = 8;
	localparam int SETTLE         = CELLS + 12;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic [MASK_N-1:0] mask;
		logic              gate;
		verdict_t          vd;
		logic [VOLT_W-1:0] lo;
		logic [VOLT_W-1:0] hi;
	} frame_decision_t;

	typedef struct packed {
		logic [VOLT_W-1:0]       volt;
		logic                    last;
		logic signed [CUR_W-1:0] cur;
		logic                    flt;
		logic                    known;
		frame_decision_t         want;
	} cell_row_t;

	localparam frame_decision_t NO_CHECK = '0;

	localparam logic [CFG_W-1:0] RESET_VALUES [N_REGS] = '{
		CFG_W'(RST_TARGET), CFG_W'(RST_DONE_WIN), CFG_W'(RST_BAL_START),
		CFG_W'(RST_BAL_DELTA), CFG_W'(RST_EMERG), CFG_W'(RST_DRAIN_WIN),
		CFG_W'(RST_GATE_DLT), CFG_W'(RST_REMOVAL)
	};

	// directed frames under reset settings; rows marked known carry their decision
	localparam cell_row_t DIRECTED_ROWS [25] = '{
		'{16'd0,     1'b1, 18'sd0,      1'b0, 1'b1, '{20'h0, 1'b0, VD_CHARGING, 16'd0, 16'd0}},
		'{16'd65535, 1'b1, 18'sd0,      1'b0, 1'b1,
			'{20'h0, 1'b1, VD_COMPLETE, 16'd65535, 16'd65535}},
		'{16'd65535, 1'b1, 18'sd0,      1'b0, 1'b1,
			'{20'h0, 1'b1, VD_COMPLETE, 16'd65535, 16'd65535}},
		'{16'd0,     1'b1, 18'sd0,      1'b0, 1'b1, '{20'h0, 1'b0, VD_CHARGING, 16'd0, 16'd0}},
		'{16'd40000, 1'b1, 18'h20000,   1'b1, 1'b1,
			'{20'h0, 1'b1, VD_FAULT, 16'd40000, 16'd40000}},
		'{16'd40000, 1'b0, 18'sd0,      1'b0, 1'b0, NO_CHECK},
		'{16'd40100, 1'b0, 18'sd0,      1'b0, 1'b0, NO_CHECK},
		'{16'd40020, 1'b1, 18'sd0,      1'b0, 1'b0, NO_CHECK},
		'{16'd40010, 1'b1, 18'sd0,      1'b0, 1'b0, NO_CHECK},
		'{16'd1000,  1'b1, 18'sd131071, 1'b0, 1'b1,
			'{20'h0, 1'b1, VD_REMOVED, 16'd1000, 16'd1000}},
		'{16'd0,     1'b1, 18'sd99900,  1'b0, 1'b1, '{20'h0, 1'b0, VD_CHARGING, 16'd0, 16'd0}},
		'{16'd0,     1'b1, 18'sd99900,  1'b0, 1'b1, '{20'h0, 1'b0, VD_CHARGING, 16'd0, 16'd0}},
		'{16'd38000, 1'b0, 18'sd0,      1'b0, 1'b0, NO_CHECK},
		'{16'd39000, 1'b1, 18'sd0,      1'b0, 1'b0, NO_CHECK},
		'{16'd38000, 1'b1, 18'sd0,      1'b0, 1'b0, NO_CHECK},
		'{16'd40700, 1'b0, 18'sd0,      1'b0, 1'b0, NO_CHECK},
		'{16'd41000, 1'b1, 18'sd0,      1'b0, 1'b0, NO_CHECK},
		'{16'd40000, 1'b1, 18'sd0,      1'b0, 1'b0, NO_CHECK},
		'{16'd38000, 1'b0, 18'sd0,      1'b0, 1'b0, NO_CHECK},
		'{16'd38300, 1'b0, 18'sd0,      1'b0, 1'b0, NO_CHECK},
		'{16'd38100, 1'b0, 18'sd0,      1'b0, 1'b0, NO_CHECK},
		'{16'd38260, 1'b1, 18'sd0,      1'b0, 1'b0, NO_CHECK},
		'{16'd37000, 1'b0, 18'sd0,      1'b0, 1'b0, NO_CHECK},
		'{16'd38000, 1'b1, 18'sd0,      1'b0, 1'b0, NO_CHECK},
		'{16'd37000, 1'b1, 18'sd0,      1'b0, 1'b0, NO_CHECK}
	};

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic [VOLT_W-1:0]       cell_voltage;
	logic                    last_cell;
	logic signed [CUR_W-1:0] pack_current;
	logic                    fault_active;
	logic                    out_valid;
	logic                    out_ready;
	logic [MASK_N-1:0]       balance_mask;
	logic                    charge_gate_open;
	logic [2:0]              verdict;
	logic [VOLT_W-1:0]       min_cell;
	logic [VOLT_W-1:0]       max_cell;
	logic                    cfg_we;
	reg_idx_t                cfg_index;
	logic [CFG_W-1:0]        cfg_data;

	// mirror of the block: settings, frame store and decision state
	logic [VOLT_W-1:0] target_q, done_win_q, bal_start_q, bal_delta_q;
	logic [VOLT_W-1:0] emerg_q, drain_win_q, gate_dlt_q;
	logic [RCUR_W-1:0] removal_q;
	logic [VOLT_W-1:0] frame_cells [CELLS];
	int unsigned       run_lo, run_hi, cell_count;
	bit                gate_q;
	logic [MASK_N-1:0] mask_q;

	frame_decision_t   frame_verdicts_due [$];
	logic [CFG_W-1:0]  reg_plan [N_REGS];
	bit                steady;
	int                mismatches = 0;
	int                idle_cycles = 0;

	always begin
		#5ns clk = 1'b1;
		#5ns clk = 1'b0;
	end

	cell_charge_balance_controller #(.CELLS(CELLS)) dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.cell_voltage    (cell_voltage),
		.last_cell       (last_cell),
		.pack_current    (pack_current),
		.fault_active    (fault_active),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.balance_mask    (balance_mask),
		.charge_gate_open(charge_gate_open),
		.verdict         (verdict),
		.min_cell        (min_cell),
		.max_cell        (max_cell),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	function automatic void restart_frame();
		run_lo = 16'hFFFF;
		run_hi = 0;
		cell_count = 0;
	endfunction

	function automatic void latch_setting(input reg_idx_t r, input logic [CFG_W-1:0] d);
		case (r)
			REG_TARGET:    target_q    = d[VOLT_W-1:0];
			REG_DONE_WIN:  done_win_q  = d[VOLT_W-1:0];
			REG_BAL_START: bal_start_q = d[VOLT_W-1:0];
			REG_BAL_DELTA: bal_delta_q = d[VOLT_W-1:0];
			REG_EMERG:     emerg_q     = d[VOLT_W-1:0];
			REG_DRAIN_WIN: drain_win_q = d[VOLT_W-1:0];
			REG_GATE_DLT:  gate_dlt_q  = d[VOLT_W-1:0];
			REG_REMOVAL:   removal_q   = d[RCUR_W-1:0];
			default: ;
		endcase
	endfunction

	// cells of this frame at or above floor_v and strictly above the threshold
	function automatic logic [MASK_N-1:0] cells_above(input int unsigned floor_v,
			input int unsigned above);
		logic [MASK_N-1:0] m;
		m = '0;
		for (int i = 0; i < cell_count && i < MASK_N && i < CELLS; i++)
			if (frame_cells[i] >= floor_v && frame_cells[i] > above)
				m[i] = 1'b1;
		return m;
	endfunction

	function automatic bit judge_cell(input logic [VOLT_W-1:0] v, input logic last,
			input logic signed [CUR_W-1:0] cur, input logic flt,
			output frame_decision_t res);
		int unsigned lo, hi, spread;
		int          cur_i, rem_i;
		bit          complete;
		verdict_t    vd;
		res = '0;
		// drop cells past the store depth
		if (cell_count < CELLS) begin
			frame_cells[cell_count] = v;
			if (v < run_lo)
				run_lo = v;
			if (v > run_hi)
				run_hi = v;
			cell_count++;
		end
		if (!last)
			return 1'b0;
		lo = run_lo;
		hi = run_hi;
		spread = (hi >= lo) ? hi - lo : 0;
		complete = (lo + done_win_q) >= target_q;
		cur_i = cur;
		rem_i = removal_q;
		if (flt) begin
			mask_q = '0;
			gate_q = 1'b1;
			vd = VD_FAULT;
		end else if (gate_q) begin
			mask_q = cells_above(0, lo + drain_win_q);
			vd = VD_DRAINING;
			if (spread <= drain_win_q) begin
				mask_q = '0;
				if (complete) begin
					vd = VD_COMPLETE;
				end else begin
					gate_q = 1'b0;
					vd = VD_CHARGING;
				end
			end
		end else if (cur_i > rem_i) begin
			mask_q = '0;
			gate_q = 1'b1;
			vd = VD_REMOVED;
		end else if (spread >= emerg_q) begin
			gate_q = 1'b1;
			vd = VD_GATE_OPEN;
		end else if (hi >= target_q && spread > gate_dlt_q) begin
			gate_q = 1'b1;
			vd = VD_GATE_OPEN;
		end else if (complete) begin
			mask_q = '0;
			gate_q = 1'b1;
			vd = VD_COMPLETE;
		end else begin
			mask_q = cells_above(bal_start_q, lo + bal_delta_q);
			vd = VD_CHARGING;
		end
		res.mask = mask_q;
		res.gate = gate_q;
		res.vd = vd;
		res.lo = lo[VOLT_W-1:0];
		res.hi = hi[VOLT_W-1:0];
		restart_frame();
		return 1'b1;
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		$display("mismatch %s: got 0x%0h want 0x%0h at %0t", what, got, want, $time);
	endtask

	task automatic send_cell(input logic [VOLT_W-1:0] v, input logic last,
			input logic signed [CUR_W-1:0] cur, input logic flt, input logic known,
			input frame_decision_t want);
		int              gap;
		frame_decision_t pred;
		gap = steady ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cell_voltage <= v;
		last_cell <= last;
		pack_current <= cur;
		fault_active <= flt;
		@(negedge clk);
		while (!in_ready)
			@(negedge clk);
		@(posedge clk);
		if (judge_cell(v, last, cur, flt, pred))
			frame_verdicts_due.push_back(known ? want : pred);
	endtask

	// hold input off until every decision is out and the mask pass has drained
	task automatic settle();
		in_valid <= 1'b0;
		while (frame_verdicts_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic program_regs();
		for (int i = 0; i < N_REGS; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= reg_idx_t'(i);
			cfg_data <= reg_plan[i];
			latch_setting(reg_idx_t'(i), reg_plan[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		int                      items, ncells, center, base, span, v, cur_i;
		int                      dflt, jit, maxv;
		logic signed [CUR_W-1:0] cur;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		cell_voltage <= '0;
		last_cell <= 1'b0;
		pack_current <= '0;
		fault_active <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_TARGET;
		cfg_data <= '0;
		steady = 1'b0;
		for (int i = 0; i < N_REGS; i++)
			latch_setting(reg_idx_t'(i), RESET_VALUES[i]);
		restart_frame();
		gate_q = 1'b0;
		mask_q = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[i])
			send_cell(DIRECTED_ROWS[i].volt, DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].cur,
				DIRECTED_ROWS[i].flt, DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].want);

		for (int phase = 0; phase < N_PHASES; phase++) begin
			settle();
			for (int r = 0; r < N_REGS; r++) begin
				case (phase)
					0: reg_plan[r] = '0;
					1: reg_plan[r] = '1;
					2: reg_plan[r] = RESET_VALUES[r];
					default: begin
						if ($urandom_range(0, 3) == 0) begin
							reg_plan[r] = CFG_W'($urandom);
						end else begin
							// jitter around the reset value
							dflt = RESET_VALUES[r];
							jit = dflt / 4 + 20;
							v = dflt - jit + int'($urandom_range(0, 2 * jit));
							maxv = (reg_idx_t'(r) == REG_REMOVAL) ? 131071 : 65535;
							if (v < 0)
								v = 0;
							if (v > maxv)
								v = maxv;
							reg_plan[r] = CFG_W'(v);
						end
					end
				endcase
			end
			program_regs();

			items = 0;
			while (items < N_ITEMS / N_PHASES) begin
				steady = ($urandom_range(0, 5) == 0);
				case ($urandom_range(0, 15))
					0: ncells = 1;
					1: ncells = $urandom_range(CELLS + 1, CELLS + 4);
					default: ncells = $urandom_range(2, CELLS);
				endcase
				case ($urandom_range(0, 3))
					0: center = $urandom_range(0, 65535);
					1: center = target_q;
					2: center = bal_start_q;
					default: center = int'(target_q) - int'(done_win_q);
				endcase
				base = center - int'($urandom_range(0, 400));
				case ($urandom_range(0, 3))
					0: span = $urandom_range(0, 40);
					1: span = $urandom_range(0, 400);
					2: span = $urandom_range(0, 1500);
					default: span = $urandom_range(0, 65535);
				endcase
				for (int c = 0; c < ncells; c++) begin
					v = base + int'($urandom_range(0, span));
					if (v < 0)
						v = 0;
					if (v > 65535)
						v = 65535;
					if (c == ncells - 1) begin
						case ($urandom_range(0, 7))
							0, 1: cur_i = $urandom;
							2: begin
								cur_i = int'(removal_q) + int'($urandom_range(0, 4)) - 2;
								if (cur_i > 131071)
									cur_i = 131071;
							end
							default: cur_i = int'($urandom_range(0, 4000)) - 2000;
						endcase
						cur = CUR_W'(cur_i);
						send_cell(VOLT_W'(v), 1'b1, cur, ($urandom_range(0, 11) == 0),
							1'b0, NO_CHECK);
					end else begin
						send_cell(VOLT_W'(v), 1'b0, CUR_W'($urandom), 1'($urandom),
							1'b0, NO_CHECK);
					end
				end
				items += ncells;
			end
		end

		settle();
		if (mismatches == 0)
			$display("cell_charge_balance_controller_tb OK");
		else
			$display("cell_charge_balance_controller_tb NOT OK");
		$finish;
	end

	initial begin : result_sink
		int              gap;
		frame_decision_t got, want;
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			gap = steady ? 0 : $urandom_range(0, 4);
			// stall the word once it shows up
			if (gap > 0) begin
				out_ready <= 1'b0;
				@(negedge clk);
				while (!out_valid)
					@(negedge clk);
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(negedge clk);
			while (!out_valid)
				@(negedge clk);
			got = '{balance_mask, charge_gate_open, verdict_t'(verdict), min_cell, max_cell};
			@(posedge clk);
			if (frame_verdicts_due.size() == 0) begin
				flag_mismatch("result word with none pending", got.mask, 0);
			end else begin
				want = frame_verdicts_due.pop_front();
				if (got.mask !== want.mask)
					flag_mismatch("balance_mask", got.mask, want.mask);
				if (got.gate !== want.gate)
					flag_mismatch("charge_gate_open", got.gate, want.gate);
				if (got.vd !== want.vd)
					flag_mismatch("verdict", got.vd, want.vd);
				if (got.lo !== want.lo)
					flag_mismatch("min_cell", got.lo, want.lo);
				if (got.hi !== want.hi)
					flag_mismatch("max_cell", got.hi, want.hi);
			end
		end
	end

	always @(negedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("cell_charge_balance_controller_tb NOT OK");
			$finish;
		end
	end

endmodule
